>>> hw/rtl/sync_word_frame_checksum_deframer_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef SYNC_WORD_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWFCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SWFCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> hw/rtl/swfcd_pkg.sv
// Shared constants and controller/datapath interface types for the deframer.
package swfcd_pkg;

  localparam int FRAME_LEN_DEF = 32;

  localparam logic [7:0] SYNC_A = 8'h55;
  localparam logic [7:0] SYNC_B = 8'hAA;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_WAIT_B = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic KIND_GOOD = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  typedef struct packed {
    logic take;
    logic rd;
    logic ptr_clr;
    logic ptr_inc;
    logic scan_init;
    logic scan_step;
    logic copy_start;
    logic copy_wr;
    logic set_body;
    logic nohdr;
    logic hunt_clr;
    logic out_good;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic sum_ok;
    logic ptr_last;
    logic hdr_hit;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/swfcd_dp.sv
// Deframer datapath: frame store, counters, checksum and output register.
module swfcd_dp #(
  parameter int FRAME_LEN = swfcd_pkg::FRAME_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swfcd_pkg::cmd_t    cmd,
  output swfcd_pkg::stat_t   stat,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_kind,
  output logic [7:0]         out_frame_byte,
  output logic [4:0]         out_byte_index,
  output logic               out_last
);

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam int CNT_W = $clog2(FRAME_LEN + 1);

  localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FILL_SUM_HI = CNT_W'(FRAME_LEN - 2);

  logic [7:0]       mem [FRAME_LEN];
  logic [7:0]       rd_data_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] dst_r, dst_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             prev_ok_r, prev_ok_nxt;

  logic             we;
  logic [IDX_W-1:0] wa;
  logic [7:0]       wd;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [7:0]       out_frame_byte_r;
  logic [4:0]       out_byte_index_r;
  logic             out_last_r;

  logic [IDX_W+4:0] ptr_ext;

  assign ptr_ext = (IDX_W + 5)'(ptr_r);

  assign stat.frame_done = (phase_r == swfcd_pkg::PH_BODY) && (fill_r == FILL_LAST);
  assign stat.sum_ok     = (sum_r == chk_r);
  assign stat.ptr_last   = (ptr_r == PTR_LAST);
  assign stat.hdr_hit    = prev_ok_r && (prev_r == swfcd_pkg::SYNC_A) &&
                           (rd_data_r == swfcd_pkg::SYNC_B);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    chk_nxt     = chk_r;
    dst_nxt     = dst_r;
    prev_nxt    = prev_r;
    prev_ok_nxt = prev_ok_r;
    we          = 1'b0;
    wa          = fill_r[IDX_W-1:0];
    wd          = in_rx_byte;

    if (cmd.take) begin
      unique case (phase_r)
        swfcd_pkg::PH_WAIT_B: begin
          if (in_rx_byte == swfcd_pkg::SYNC_B) begin
            we        = 1'b1;
            wa        = IDX_W'(1);
            fill_nxt  = CNT_W'(2);
            sum_nxt   = 8'd0;
            phase_nxt = swfcd_pkg::PH_BODY;
          end else if (in_rx_byte == swfcd_pkg::SYNC_A) begin
            fill_nxt = CNT_W'(1);
          end else begin
            fill_nxt  = '0;
            phase_nxt = swfcd_pkg::PH_HUNT;
          end
        end
        swfcd_pkg::PH_BODY: begin
          we       = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
          if (fill_r >= CNT_W'(2) && fill_r <= FILL_SUM_HI) begin
            sum_nxt = sum_r + in_rx_byte;
          end
          if (fill_r == FILL_LAST) begin
            chk_nxt = in_rx_byte;
          end
        end
        default: begin
          if (in_rx_byte == swfcd_pkg::SYNC_A) begin
            we        = 1'b1;
            wa        = '0;
            fill_nxt  = CNT_W'(1);
            phase_nxt = swfcd_pkg::PH_WAIT_B;
          end else begin
            fill_nxt  = '0;
            phase_nxt = swfcd_pkg::PH_HUNT;
          end
        end
      endcase
    end

    if (cmd.hunt_clr) begin
      fill_nxt  = '0;
      sum_nxt   = 8'd0;
      phase_nxt = swfcd_pkg::PH_HUNT;
    end

    if (cmd.scan_init) begin
      prev_ok_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      prev_nxt    = rd_data_r;
      prev_ok_nxt = 1'b1;
    end

    if (cmd.copy_start) begin
      dst_nxt = '0;
      sum_nxt = 8'd0;
    end
    if (cmd.copy_wr) begin
      we      = 1'b1;
      wa      = dst_r;
      wd      = rd_data_r;
      dst_nxt = dst_r + IDX_W'(1);
      if (dst_r >= IDX_W'(2)) begin
        sum_nxt = sum_r + rd_data_r;
      end
    end
    if (cmd.set_body) begin
      fill_nxt  = CNT_W'(dst_r) + CNT_W'(1);
      phase_nxt = swfcd_pkg::PH_BODY;
    end

    if (cmd.nohdr) begin
      sum_nxt = 8'd0;
      if (chk_r == swfcd_pkg::SYNC_A) begin
        fill_nxt  = CNT_W'(1);
        phase_nxt = swfcd_pkg::PH_WAIT_B;
      end else begin
        fill_nxt  = '0;
        phase_nxt = swfcd_pkg::PH_HUNT;
      end
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    priority if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.scan_init) begin
      ptr_nxt = IDX_W'(2);
    end else if (cmd.copy_start) begin
      ptr_nxt = ptr_r - IDX_W'(1);
    end else if (cmd.ptr_inc || cmd.scan_step) begin
      ptr_nxt = ptr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= swfcd_pkg::PH_HUNT;
      fill_r      <= '0;
      sum_r       <= 8'd0;
      ptr_r       <= '0;
      prev_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
      ptr_r     <= ptr_nxt;
      prev_ok_r <= prev_ok_nxt;
      if (cmd.out_good || cmd.out_err) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r  <= chk_nxt;
    dst_r  <= dst_nxt;
    prev_r <= prev_nxt;
    if (cmd.out_good) begin
      out_kind_r       <= swfcd_pkg::KIND_GOOD;
      out_frame_byte_r <= rd_data_r;
      out_byte_index_r <= ptr_ext[4:0];
      out_last_r       <= (ptr_r == PTR_LAST);
    end else if (cmd.out_err) begin
      out_kind_r       <= swfcd_pkg::KIND_ERR;
      out_frame_byte_r <= 8'd0;
      out_byte_index_r <= 5'd0;
      out_last_r       <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_byte_index = out_byte_index_r;
  assign out_last       = out_last_r;

endmodule

>>> hw/rtl/swfcd_ctrl.sv
// Deframer controller: sequences byte intake, check, emission and rescan.
module swfcd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  swfcd_pkg::stat_t stat,
  output swfcd_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_EMIT_RD  = 4'd2;
  localparam logic [3:0] S_EMIT_LD  = 4'd3;
  localparam logic [3:0] S_ERR      = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_COPY_RD  = 4'd7;
  localparam logic [3:0] S_COPY_WR  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.frame_done) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.sum_ok) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_EMIT_RD;
        end else begin
          state_nxt = S_ERR;
        end
      end
      S_EMIT_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.out_good = 1'b1;
          if (stat.ptr_last) begin
            cmd.hunt_clr = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = S_EMIT_RD;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.out_err   = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (stat.hdr_hit) begin
          cmd.copy_start = 1'b1;
          state_nxt      = S_COPY_RD;
        end else if (stat.ptr_last) begin
          cmd.nohdr = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_COPY_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (stat.ptr_last) begin
          cmd.set_body = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_COPY_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/sync_word_frame_checksum_deframer.sv
// Sync-word deframer with additive checksum: top level.
// Input channel: one received byte per beat (in_valid/in_stall, in_rx_byte).
// Output channel: one result per beat (out_valid/out_stall); out_kind is 0
// for a frame byte with out_frame_byte/out_byte_index, 1 for a checksum
// error; out_last marks the final result caused by one input byte.
// A byte is taken whenever the controller is idle. A byte that completes
// a FRAME_LEN-byte frame holds the input for the checksum check, then a
// good frame is read back from the frame store one byte at a time: each
// byte is read, then loaded into the output register.
// A failed check gives one error beat, then a rescan of stored bytes 2 up
// to FRAME_LEN-1, each read, then compared; when a new header is found,
// the bytes from its 0x55 onward are read and moved down to the start.
// A waiting result sits in the output register; the next byte is taken
// while it waits unless more results are due, which then wait for it.
// Reset (rst_n low, synchronous) empties the store and restarts the hunt
// for the 0x55 0xAA header; no clearing pass is needed.
module sync_word_frame_checksum_deframer #(
  parameter int FRAME_LEN = swfcd_pkg::FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_frame_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last
);

  swfcd_pkg::cmd_t  cmd;
  swfcd_pkg::stat_t stat;

  swfcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swfcd_dp #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_rx_byte     (in_rx_byte),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

>>> hw/rtl/swfcd_chk.sv
// Port-level checker for the deframer, bound to the top level.
`include "sync_word_frame_checksum_deframer_defines.svh"

module swfcd_chk #(
  parameter int FRAME_LEN = swfcd_pkg::FRAME_LEN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_frame_byte,
  input logic [4:0] out_byte_index,
  input logic       out_last
);

  localparam logic [4:0] LAST_IDX = 5'((FRAME_LEN - 1) % 32);

  `SWFCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_frame_byte))

  `SWFCD_ASSERT_SAME(a_err_shape, out_valid && (out_kind == swfcd_pkg::KIND_ERR), out_last && (out_frame_byte == 8'd0) && (out_byte_index == 5'd0))

  `SWFCD_ASSERT_SAME(a_good_last_idx, out_valid && (out_kind == swfcd_pkg::KIND_GOOD) && out_last, out_byte_index == LAST_IDX)

  `SWFCD_ASSERT_SAME(a_emit_blocks_in, out_valid && (out_kind == swfcd_pkg::KIND_GOOD) && !out_last, in_stall)

endmodule

bind sync_word_frame_checksum_deframer swfcd_chk #(.FRAME_LEN(FRAME_LEN)) u_swfcd_chk (.*);
